// File: rtl/gec_pkg.sv
// Shared types, sizes and helpers for the greedy edge colorer.
// Used by every module of the block but gec_ram; depends on nothing else.
package gec_pkg;

   // Sizes of the vertex table and the color palette
   localparam int Vertices   = 4096;
   localparam int Colors     = 64;
   localparam int AddrWidth  = $clog2(Vertices);
   // Generation tag kept with every mask entry; a restart moves to a new tag
   localparam int EpochWidth = 4;
   localparam int EntryWidth = EpochWidth + Colors;
   localparam int SlotCount  = 64;
   localparam int GroupSize  = 8;
   localparam int GroupCount = SlotCount / GroupSize;

   localparam logic [EpochWidth-1:0] EpochMax   = '1;
   localparam logic [EpochWidth-1:0] EpochFirst = EpochWidth'(1);
   localparam logic [EpochWidth-1:0] EpochClear = '0;

   // Input item
   typedef struct packed {
      logic [11:0] src_vtx;
      logic [11:0] dst_vtx;
      logic        restart;
   } req_type;

   // Result item
   typedef struct packed {
      logic [5:0] color;
      logic       overflow;
      logic [6:0] colors_used;
   } rsp_type;

   // Controller states
   typedef enum logic [4:0] {
      ST_CLEAR   = 5'b00001,
      ST_IDLE    = 5'b00010,
      ST_ISSUE   = 5'b00100,
      ST_CALC    = 5'b01000,
      ST_WRITE_B = 5'b10000
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;    // load the item, handle restart bookkeeping
      logic rd_held;   // read from the held item instead of the ports
      logic clear;     // write one zero entry of the clearing pass
      logic calc;      // pick color, write endpoint A, post result
      logic write_b;   // write endpoint B
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic epoch_full;
      logic clear_last;
   } status_type;

   typedef struct packed {
      logic       found;
      logic [5:0] index;
   } pick_type;

   // Lowest set bit of a 64-bit word: first the group, then the bit in it
   function automatic pick_type first_free(input logic [SlotCount-1:0] free_bits);
      pick_type                    pick;
      logic [GroupCount-1:0]       group_any;
      logic [2:0]                  group_sel;
      logic [GroupSize-1:0]        group_bits;
      logic [2:0]                  bit_sel;
      for (int g = 0; g < GroupCount; g++) begin
         group_any[g] = |free_bits[g*GroupSize +: GroupSize];
      end
      group_sel = '0;
      for (int g = GroupCount - 1; g >= 0; g--) begin
         if (group_any[g]) begin
            group_sel = 3'(g);
         end
      end
      group_bits = free_bits[group_sel*GroupSize +: GroupSize];
      bit_sel = '0;
      for (int b = GroupSize - 1; b >= 0; b--) begin
         if (group_bits[b]) begin
            bit_sel = 3'(b);
         end
      end
      pick.found = |group_any;
      pick.index = {group_sel, bit_sel};
      return pick;
   endfunction

endpackage

// File: rtl/gec_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// Standalone; no package dependency.
module gec_ram #(
   parameter int Width = 8,
   parameter int Depth = 16,
   localparam int AddrWidth = $clog2(Depth)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [Width-1:0]     wr_data,
   input  logic [AddrWidth-1:0] rd_addr_a,
   input  logic [AddrWidth-1:0] rd_addr_b,
   output logic [Width-1:0]     rd_data_a,
   output logic [Width-1:0]     rd_data_b
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_a_ff;
   logic [Width-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// File: rtl/gec_ctrl.sv
// Sequencing state machine of the greedy edge colorer.
// Depends on gec_pkg; drives the datapath through cmd_type.
module gec_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_restart,
   input  gec_pkg::status_type status,
   output gec_pkg::cmd_type    cmd,
   output logic                busy
);
   import gec_pkg::*;

   state_type state_ff, state_in;
   logic      pend_ff, pend_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = pend_ff ? ST_ISSUE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               if (req_restart && status.epoch_full) begin
                  state_in = ST_CLEAR;
                  pend_in  = 1'b1;
               end else begin
                  state_in = ST_CALC;
               end
            end
         end
         ST_ISSUE: begin
            cmd.rd_held = 1'b1;
            pend_in     = 1'b0;
            state_in    = ST_CALC;
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_WRITE_B;
         end
         ST_WRITE_B: begin
            cmd.write_b = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// File: rtl/gec_dp.sv
// Datapath of the greedy edge colorer: mask table, color pick, count, result.
// Depends on gec_pkg and gec_ram; steered by gec_ctrl through cmd_type.
module gec_dp (
   input  logic                clock,
   input  logic                reset,
   input  gec_pkg::req_type    req_item,
   input  gec_pkg::cmd_type    cmd,
   output gec_pkg::status_type status,
   output logic                rsp_valid,
   output gec_pkg::rsp_type    rsp_item
);
   import gec_pkg::*;

   req_type                 item_ff;
   logic [EpochWidth-1:0]   epoch_ff, epoch_in;
   logic [AddrWidth-1:0]    clr_addr_ff, clr_addr_in;
   logic [6:0]              count_ff, count_in;
   logic [Colors-1:0]       new_b_ff;
   logic                    ovf_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;

   logic [AddrWidth-1:0]    rd_addr_a, rd_addr_b;
   logic [AddrWidth-1:0]    addr_a, addr_b;
   logic                    in_a, in_b;
   logic [EntryWidth-1:0]   rd_data_a, rd_data_b;
   logic [Colors-1:0]       mask_a, mask_b;
   logic [SlotCount-1:0]    free_bits;
   pick_type                pick;
   logic [Colors-1:0]       color_bit;
   logic [6:0]              color_next;
   logic                    wr_en;
   logic [AddrWidth-1:0]    wr_addr;
   logic [EntryWidth-1:0]   wr_data;

   // Endpoints of the held item
   assign addr_a = AddrWidth'(item_ff.src_vtx);
   assign addr_b = AddrWidth'(item_ff.dst_vtx);
   assign in_a   = (32'(item_ff.src_vtx) < Vertices);
   assign in_b   = (32'(item_ff.dst_vtx) < Vertices);

   // Reads go out on the accept edge, or from the held item after a clear
   assign rd_addr_a = cmd.rd_held ? addr_a : AddrWidth'(req_item.src_vtx);
   assign rd_addr_b = cmd.rd_held ? addr_b : AddrWidth'(req_item.dst_vtx);

   gec_ram #(
      .Width(EntryWidth),
      .Depth(Vertices)
   ) u_mask_ram (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr_a(rd_addr_a),
      .rd_addr_b(rd_addr_b),
      .rd_data_a(rd_data_a),
      .rd_data_b(rd_data_b)
   );

   // Stale tag or out-of-range endpoint reads as an empty mask
   assign mask_a = (in_a && rd_data_a[EntryWidth-1 -: EpochWidth] == epoch_ff)
                   ? rd_data_a[Colors-1:0] : '0;
   assign mask_b = (in_b && rd_data_b[EntryWidth-1 -: EpochWidth] == epoch_ff)
                   ? rd_data_b[Colors-1:0] : '0;

   // First fit over colors free at both ends
   assign free_bits  = SlotCount'(~(mask_a | mask_b));
   assign pick       = first_free(free_bits);
   assign color_bit  = Colors'(1) << pick.index;
   assign color_next = {1'b0, pick.index} + 7'd1;

   // Table write port: clearing pass, endpoint A, endpoint B
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_addr_ff;
      wr_data = {EpochClear, {Colors{1'b0}}};
      if (cmd.clear) begin
         wr_en = 1'b1;
      end else if (cmd.calc) begin
         wr_en   = in_a && pick.found;
         wr_addr = addr_a;
         wr_data = {epoch_ff, mask_a | color_bit};
      end else if (cmd.write_b) begin
         wr_en   = in_b && !ovf_ff;
         wr_addr = addr_b;
         wr_data = {epoch_ff, new_b_ff};
      end
   end

   // Epoch, clear sweep and color count
   always_comb begin
      epoch_in    = epoch_ff;
      clr_addr_in = clr_addr_ff;
      count_in    = count_ff;
      if (cmd.clear) begin
         if (status.clear_last) begin
            clr_addr_in = '0;
            epoch_in    = EpochFirst;
         end else begin
            clr_addr_in = clr_addr_ff + AddrWidth'(1);
         end
      end
      if (cmd.accept && req_item.restart) begin
         count_in = '0;
         if (!status.epoch_full) begin
            epoch_in = epoch_ff + EpochWidth'(1);
         end
      end
      if (cmd.calc && pick.found && color_next > count_ff) begin
         count_in = color_next;
      end
   end

   assign status.epoch_full = (epoch_ff == EpochMax);
   assign status.clear_last = (clr_addr_ff == AddrWidth'(Vertices - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff     <= EpochClear;
         clr_addr_ff  <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         epoch_ff     <= epoch_in;
         clr_addr_ff  <= clr_addr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= cmd.calc;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_ff <= req_item;
      end
      if (cmd.calc) begin
         new_b_ff             <= mask_b | color_bit;
         ovf_ff               <= !pick.found;
         rsp_ff.color         <= pick.found ? pick.index : 6'd0;
         rsp_ff.overflow      <= !pick.found;
         rsp_ff.colors_used   <= count_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// File: rtl/greedy_edge_colorer_core.sv
// Top level of the greedy first-fit edge colorer.
// Depends on gec_pkg, gec_ctrl, gec_dp (which holds the gec_ram mask table).
//
// An edge is taken when start is high and busy is low. Its result is registered
// on rsp_item after the color pick step, with rsp_valid high for one cycle; the
// receiver must take it then. An edge passes through three steps (accept,
// color pick with the write of the first endpoint, write of the second
// endpoint), split by the single write port of the mask table. After reset the
// table is swept to zero, one entry per cycle, over all Vertices (4096) entries
// with busy high. A restart normally costs nothing: it moves the table to a new
// generation tag. Every fifteenth restart runs out of tags and repeats the sweep,
// then a reissue step, before that edge is handled.
module greedy_edge_colorer_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  gec_pkg::req_type req_item,
   output logic             rsp_valid,
   output gec_pkg::rsp_type rsp_item
);
   import gec_pkg::*;

   cmd_type    cmd;
   status_type status;

   gec_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_restart(req_item.restart),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy)
   );

   gec_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .status   (status),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

endmodule

// File: dv/greedy_edge_colorer_core_test.sv
// Self-checking testbench for greedy_edge_colorer_core: edges are fed through the
// start/busy port and every result is compared with a first-fit coloring predictor.
// Depends on gec_pkg and the RTL of greedy_edge_colorer_core.
module greedy_edge_colorer_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import gec_pkg::*;

   // Cycles with no accepted item or result before the run is declared hung;
   // covers the sweep after reset and the sweep that a restart can trigger
   localparam int StallLimit = 20000;
   localparam int ReportMax  = 10;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   // Predictor state: per-vertex used-color masks, live bits, colors in use
   logic [Colors-1:0] color_mask [Vertices];
   bit                mask_live [Vertices];
   int                palette_count;

   rsp_type pending_colors [$];
   int      error_count;
   int      stall_cycles;
   int      edges_sent;
   bit      steady;

   greedy_edge_colorer_core u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mask of one endpoint; a stale or out-of-range entry reads as empty
   function automatic logic [Colors-1:0] endpoint_mask(input logic [11:0] v);
      if (int'(v) >= Vertices || !mask_live[v]) begin
         return '0;
      end
      return color_mask[v];
   endfunction

   function automatic void mark_color(input logic [11:0] v, input int pick);
      if (int'(v) < Vertices) begin
         color_mask[v] = endpoint_mask(v) | (Colors'(1) << pick);
         mask_live[v]  = 1'b1;
      end
   endfunction

   // First-fit color for one edge; updates the predictor state
   function automatic rsp_type color_edge(input req_type item);
      logic [Colors-1:0] taken;
      rsp_type           res;
      int                pick;
      if (item.restart) begin
         foreach (mask_live[v]) mask_live[v] = 1'b0;
         palette_count = 0;
      end
      taken = endpoint_mask(item.src_vtx) | endpoint_mask(item.dst_vtx);
      pick  = -1;
      for (int c = Colors - 1; c >= 0; c--) begin
         if (!taken[c]) pick = c;
      end
      res.overflow = (pick < 0);
      if (pick < 0) begin
         res.color       = '0;
         res.colors_used = 7'(palette_count);
         return res;
      end
      mark_color(item.src_vtx, pick);
      mark_color(item.dst_vtx, pick);
      if (pick + 1 > palette_count) begin
         palette_count = pick + 1;
      end
      res.color       = 6'(pick);
      res.colors_used = 7'(palette_count);
      return res;
   endfunction

   // Send one edge; called and returns at a falling edge
   task automatic send_edge(input logic [11:0] va, input logic [11:0] vb, input logic rs);
      req_type item;
      rsp_type predicted;
      item.src_vtx = va;
      item.dst_vtx = vb;
      item.restart = rs;
      while (!steady && $urandom_range(99) < 23) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start    <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy);
      predicted = color_edge(item);
      pending_colors.insert(pending_colors.size(), predicted);
      edges_sent++;
      @(negedge clock);
   endtask

   // Check each result against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_colors.size() == 0) begin
            error_count++;
            if (error_count <= ReportMax) begin
               $display("%0t: unexpected result color=%0d overflow=%0b used=%0d",
                        $realtime, rsp_item.color, rsp_item.overflow,
                        rsp_item.colors_used);
            end
         end else begin
            want = pending_colors.pop_front();
            if (rsp_item.color !== want.color || rsp_item.overflow !== want.overflow ||
                rsp_item.colors_used !== want.colors_used) begin
               error_count++;
               if (error_count <= ReportMax) begin
                  $display({"%0t: mismatch expected color=%0d overflow=%0b used=%0d,",
                            " got color=%0d overflow=%0b used=%0d"},
                           $realtime, want.color, want.overflow, want.colors_used,
                           rsp_item.color, rsp_item.overflow, rsp_item.colors_used);
               end
            end
         end
      end
   end

   // Hang detection
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid === 1'b1) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= StallLimit) begin
            $display("greedy_edge_colorer_core_test: errors");
            $finish;
         end
      end
   end

   // Extreme indices, self loops, restarts
   task automatic test_corner_edges();
      send_edge(12'd0, 12'd4095, 1'b0);
      send_edge(12'd4095, 12'd0, 1'b0);
      send_edge(12'd0, 12'd0, 1'b0);
      send_edge(12'd4095, 12'd4095, 1'b0);
      send_edge(12'hAAA, 12'h555, 1'b0);
      send_edge(12'h555, 12'hAAA, 1'b0);
      send_edge(12'hAAA, 12'h555, 1'b1);
      send_edge(12'h555, 12'h555, 1'b0);
      send_edge(12'd4095, 12'd0, 1'b1);
      send_edge(12'd0, 12'd4095, 1'b0);
      send_edge(12'd0, 12'd1, 1'b0);
      send_edge(12'd4094, 12'd4095, 1'b0);
      send_edge(12'd0, 12'd0, 1'b1);
   endtask

   // Fill every color at a hub vertex, then hit it until it overflows
   task automatic test_star_overflow(input bit hub_on_b);
      logic [11:0] hub;
      logic [11:0] spoke;
      hub = 12'($urandom);
      for (int i = 0; i < Colors; i++) begin
         spoke = hub + 12'(i + 1);
         if (hub_on_b) begin
            send_edge(spoke, hub, i == 0);
         end else begin
            send_edge(hub, spoke, i == 0);
         end
      end
      send_edge(hub, hub + 12'($urandom_range(100, 4000)), 1'b0);
      send_edge(12'($urandom), hub, 1'b0);
      send_edge(hub, hub, 1'b0);
      // spokes hold one color each, the count stays at the top
      send_edge(hub + 12'd1, hub + 12'd2, 1'b0);
      // restart on the full hub clears it before the edge
      send_edge(hub, hub, 1'b1);
   endtask

   function automatic logic [11:0] pool_vertex(input logic [11:0] base, input int pool);
      if ($urandom_range(99) < 8) begin
         return 12'($urandom);
      end
      return base + 12'($urandom_range(pool - 1));
   endfunction

   // Episodes of edges over vertex pools of varied size, mostly small, so masks fill and overflow
   task automatic test_dense_graph(input int item_goal);
      logic [11:0] base;
      int          pool;
      int          run_len;
      int          pool_kind;
      int          episode;
      logic [11:0] va;
      logic [11:0] vb;
      episode = 0;
      while (edges_sent < item_goal) begin
         pool_kind = $urandom_range(9);
         if (pool_kind < 5) begin
            pool = $urandom_range(2, 6);
         end else if (pool_kind < 8) begin
            pool = $urandom_range(7, 64);
         end else if (pool_kind < 9) begin
            pool = $urandom_range(65, 400);
         end else begin
            pool = Vertices;
         end
         base    = (pool == Vertices) ? 12'd0 : 12'($urandom);
         run_len = $urandom_range(20, 120);
         steady  = (episode >= 4 && episode <= 6);
         for (int i = 0; i < run_len; i++) begin
            va = pool_vertex(base, pool);
            vb = pool_vertex(base, pool);
            send_edge(va, vb, i == 0 || $urandom_range(99) < 3);
         end
         episode++;
      end
      steady = 1'b0;
   endtask

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_item      = '0;
      error_count   = 0;
      stall_cycles  = 0;
      edges_sent    = 0;
      steady        = 1'b0;
      palette_count = 0;
      foreach (mask_live[v]) mask_live[v] = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_corner_edges();
      steady = 1'b1;
      test_star_overflow(1'b0);
      steady = 1'b0;
      test_star_overflow(1'b1);
      test_dense_graph(1300);

      start <= 1'b0;
      while (pending_colors.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("greedy_edge_colorer_core_test: clean");
      end else begin
         $display("greedy_edge_colorer_core_test: errors");
      end
      $finish;
   end

endmodule
